@@ sv/direct_mapped_cache_with_prefetch_defines.svh @@
// Assertion macros for the direct-mapped cache with next-line prefetch.
`ifndef DIRECT_MAPPED_CACHE_WITH_PREFETCH_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_WITH_PREFETCH_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define DMC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
// next-cycle implication
`define DMC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define DMC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DMC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/dmc_pkg.sv @@
// Shared constants, types and codes of the direct-mapped cache with prefetch.
package dmc_pkg;

	localparam int SETS_LOG2  = 10;
	localparam int ADDR_BITS  = 48;
	localparam int COUNT_BITS = 32;
	localparam int MAX_OFFSET = 16;

	localparam int NUM_SETS   = 1 << SETS_LOG2;
	localparam int PF_ROWS    = NUM_SETS / 2;
	localparam int WORD_W     = ADDR_BITS + 1;

	localparam int OB_W       = 5;
	localparam int IB_W       = 4;
	localparam int SH_W       = 6;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam int IN_TDATA_W   = ((ADDR_BITS + 7) / 8) * 8;
	localparam int OUT_CNT_W    = 32;
	localparam int OUT_FIELDS_W = 3 + 5 * OUT_CNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;

	localparam logic [OB_W-1:0] OFFSET_RST = 5'd2;
	localparam logic [IB_W-1:0] INDEX_RST  = 4'd3;

	typedef logic [SETS_LOG2-1:0]  set_t;
	typedef logic [SETS_LOG2-2:0]  row_t;
	typedef logic [ADDR_BITS-1:0]  tag_t;
	typedef logic [WORD_W-1:0]     word_t;
	typedef logic [COUNT_BITS-1:0] cnt_t;

	typedef struct packed {
		logic plain_hit;
		logic plain_miss;
		logic pf_hit;
		logic pf_miss;
		logic wr;
	} evt_t;

	typedef struct packed {
		cnt_t plain_hit;
		cnt_t plain_miss;
		cnt_t pf_hit;
		cnt_t pf_miss;
		cnt_t wr;
	} cnts_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

endpackage

@@ sv/direct_mapped_cache_with_prefetch.sv @@
// Top level: two direct-mapped tag stores, one plain and one with next-line prefetch.
// Path: an accepted access goes to the stage-1 register, its result then to m_tdata.
// Throughput: one access per cycle unless m_tready stalls, set by a single tag
//   read-modify-write per store with the last write forwarded into the next lookup.
// Reset: counters and config reset at once; then a clearing pass over all 1024 sets
//   (one set per cycle) wipes the valid bits, s_tready low meanwhile.
`include "direct_mapped_cache_with_prefetch_defines.svh"
module direct_mapped_cache_with_prefetch (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dmc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dmc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dmc_pkg::IN_TDATA_W-1:0]      s_tdata,  // [47:0] address
	input  logic                                s_tuser,  // [0] kind (1 = write)
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata fields, lowest bit up: plain_hit, prefetch_hit, prefetch_done,
	// plain_hit_count, plain_miss_count, pf_hit_count, pf_miss_count,
	// write_count, zero pad
	output logic [dmc_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import dmc_pkg::*;

	// ---------------- config registers ----------------
	logic [OB_W-1:0] offset_q;
	logic [IB_W-1:0] index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RST;
			index_q  <= INDEX_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_OFFSET_BITS) begin
				offset_q <= cfg_data[OB_W-1:0];
			end else if (cfg_index == REG_INDEX_BITS) begin
				index_q <= cfg_data[IB_W-1:0];
			end
		end
	end

	// ---------------- clearing pass after reset ----------------
	state_t state_q;
	set_t   clr_q;
	logic   clearing;

	assign clearing = (state_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + set_t'(1);
					if (&clr_q) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					clr_q <= clr_q;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// ---------------- handshake ----------------
	logic vld_s1;
	logic vld_s2;
	logic s1_adv;
	logic s_acc;

	assign s1_adv   = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !clearing && (!vld_s1 || s1_adv);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = vld_s2;

	// ---------------- stage 0: address split, tag read issue ----------------
	set_t set_s0;
	tag_t tag_s0;
	logic last_s0;

	dmc_split u_split (
		.addr        (s_tdata[ADDR_BITS-1:0]),
		.offset_bits (offset_q),
		.index_bits  (index_q),
		.set         (set_s0),
		.tag         (tag_s0),
		.last        (last_s0)
	);

	logic kind_s1;
	set_t set_s1;
	tag_t tag_s1;
	logic last_s1;

	// a stalled item keeps re-reading its own set
	set_t rd_set;
	assign rd_set = s_acc ? set_s0 : set_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_s1 <= s_tuser;
			set_s1  <= set_s0;
			tag_s1  <= tag_s0;
			last_s1 <= last_s0;
		end
	end

	// ---------------- tag stores ----------------
	// word = {valid, tag}; prefetch store is split in even and odd sets so
	// that a set and its next line land in different banks
	word_t p_rd, e_rd, o_rd;
	logic  p_we, e_we, o_we;
	set_t  p_waddr;
	row_t  e_waddr, o_waddr;
	word_t wword;

	logic  phit, fhit, pdone;
	set_t  nxt_set;
	set_t  e_tgt, o_tgt;
	row_t  row_s1;

	assign nxt_set = set_s1 + set_t'(1);
	assign row_s1  = set_s1[SETS_LOG2-1:1];
	assign e_tgt   = set_s1[0] ? nxt_set : set_s1;
	assign o_tgt   = set_s1[0] ? set_s1  : nxt_set;

	always_comb begin
		if (clearing) begin
			p_we    = 1'b1;
			e_we    = 1'b1;
			o_we    = 1'b1;
			p_waddr = clr_q;
			e_waddr = clr_q[SETS_LOG2-1:1];
			o_waddr = clr_q[SETS_LOG2-1:1];
			wword   = '0;
		end else begin
			p_we    = s1_adv && !phit;
			e_we    = s1_adv && !fhit && (set_s1[0] ? pdone : 1'b1);
			o_we    = s1_adv && !fhit && (set_s1[0] ? 1'b1 : pdone);
			p_waddr = set_s1;
			e_waddr = e_tgt[SETS_LOG2-1:1];
			o_waddr = o_tgt[SETS_LOG2-1:1];
			wword   = {1'b1, tag_s1};
		end
	end

	dmc_ram #(.WIDTH(WORD_W), .DEPTH(NUM_SETS)) u_plain_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (wword),
		.raddr (rd_set),
		.rdata (p_rd)
	);

	dmc_ram #(.WIDTH(WORD_W), .DEPTH(PF_ROWS)) u_pf_even_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (wword),
		.raddr (rd_set[SETS_LOG2-1:1]),
		.rdata (e_rd)
	);

	dmc_ram #(.WIDTH(WORD_W), .DEPTH(PF_ROWS)) u_pf_odd_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (wword),
		.raddr (rd_set[SETS_LOG2-1:1]),
		.rdata (o_rd)
	);

	// ---------------- write forwarding ----------------
	// last fill of each RAM; the read of the item behind it may predate it
	logic pw_vld_q, ew_vld_q, ow_vld_q;
	set_t pw_set_q;
	row_t ew_row_q, ow_row_q;
	tag_t pw_tag_q, ew_tag_q, ow_tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_vld_q <= 1'b0;
			ew_vld_q <= 1'b0;
			ow_vld_q <= 1'b0;
		end else if (!clearing) begin
			if (p_we) pw_vld_q <= 1'b1;
			if (e_we) ew_vld_q <= 1'b1;
			if (o_we) ow_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clearing && p_we) begin
			pw_set_q <= p_waddr;
			pw_tag_q <= tag_s1;
		end
		if (!clearing && e_we) begin
			ew_row_q <= e_waddr;
			ew_tag_q <= tag_s1;
		end
		if (!clearing && o_we) begin
			ow_row_q <= o_waddr;
			ow_tag_q <= tag_s1;
		end
	end

	// ---------------- stage 1: compare ----------------
	word_t p_word, e_word, o_word, f_word;

	always_comb begin
		p_word = (pw_vld_q && (pw_set_q == set_s1)) ? {1'b1, pw_tag_q} : p_rd;
		e_word = (ew_vld_q && (ew_row_q == row_s1)) ? {1'b1, ew_tag_q} : e_rd;
		o_word = (ow_vld_q && (ow_row_q == row_s1)) ? {1'b1, ow_tag_q} : o_rd;
		f_word = set_s1[0] ? o_word : e_word;
		phit   = p_word[WORD_W-1] && (p_word[ADDR_BITS-1:0] == tag_s1);
		fhit   = f_word[WORD_W-1] && (f_word[ADDR_BITS-1:0] == tag_s1);
		pdone  = !fhit && !last_s1;
	end

	// ---------------- counters ----------------
	evt_t  evt;
	cnts_t cnts_nxt;

	assign evt = '{
		plain_hit:  phit,
		plain_miss: !phit,
		pf_hit:     fhit,
		pf_miss:    !fhit,
		wr:         kind_s1
	};

	dmc_counters u_counters (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (s1_adv),
		.evt      (evt),
		.cnts_nxt (cnts_nxt)
	);

	// ---------------- stage 2: result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_adv) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			m_tdata <= {
				OUT_PAD_W'(0),
				OUT_CNT_W'(cnts_nxt.wr),
				OUT_CNT_W'(cnts_nxt.pf_miss),
				OUT_CNT_W'(cnts_nxt.pf_hit),
				OUT_CNT_W'(cnts_nxt.plain_miss),
				OUT_CNT_W'(cnts_nxt.plain_hit),
				pdone,
				fhit,
				phit
			};
		end
	end

	// ---------------- checks ----------------
	`DMC_ASSERT_IMP(a_idle_during_clear, clk, arst_n, clearing, !vld_s1 && !vld_s2)
	`DMC_ASSERT_NXT(a_adv_gives_result, clk, arst_n, s1_adv, m_tvalid)
	`DMC_ASSERT_IMP(a_prefetch_only_on_miss, clk, arst_n, m_tvalid, !(m_tdata[2] && m_tdata[1]))

endmodule

@@ sv/dmc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/dmc_split.sv @@
// Address split into set index, tag and last-set flag under the live config.
module dmc_split (
	input  dmc_pkg::tag_t              addr,
	input  logic [dmc_pkg::OB_W-1:0]   offset_bits,
	input  logic [dmc_pkg::IB_W-1:0]   index_bits,
	output dmc_pkg::set_t              set,
	output dmc_pkg::tag_t              tag,
	output logic                       last
);
	import dmc_pkg::*;

	logic [OB_W-1:0] ob;
	logic [OB_W-1:0] ib;
	set_t            mask;
	tag_t            shifted;

	always_comb begin
		ob = (offset_bits > OB_W'(MAX_OFFSET)) ? OB_W'(MAX_OFFSET) : offset_bits;
		ib = ({1'b0, index_bits} > OB_W'(SETS_LOG2)) ? OB_W'(SETS_LOG2)
		                                              : {1'b0, index_bits};
		for (int i = 0; i < SETS_LOG2; i++) begin
			mask[i] = (i < int'(ib));
		end
		shifted = addr >> ob;
		set     = set_t'(shifted) & mask;
		tag     = addr >> (SH_W'(ob) + SH_W'(ib));
		// top set of the range in use has no next line
		last    = (set == mask);
	end

endmodule

@@ sv/dmc_counters.sv @@
// Five saturating event counters; the updated values are shown the same cycle.
module dmc_counters (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  dmc_pkg::evt_t   evt,
	output dmc_pkg::cnts_t  cnts_nxt
);
	import dmc_pkg::*;

	cnts_t cnts_q;

	function automatic cnt_t sat_inc(cnt_t c, logic inc);
		cnt_t r;
		r = c;
		if (inc && !(&c)) begin
			r = c + cnt_t'(1);
		end
		return r;
	endfunction

	always_comb begin
		cnts_nxt.plain_hit  = sat_inc(cnts_q.plain_hit,  evt.plain_hit);
		cnts_nxt.plain_miss = sat_inc(cnts_q.plain_miss, evt.plain_miss);
		cnts_nxt.pf_hit     = sat_inc(cnts_q.pf_hit,     evt.pf_hit);
		cnts_nxt.pf_miss    = sat_inc(cnts_q.pf_miss,    evt.pf_miss);
		cnts_nxt.wr         = sat_inc(cnts_q.wr,         evt.wr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnts_q <= '0;
		end else if (en) begin
			cnts_q <= cnts_nxt;
		end
	end

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the direct-mapped cache with next-line prefetch: lookup model and stream checks.
`timescale 1ns / 1ps

module tb;
	import dmc_pkg::*;

	// access kinds carried on s_tuser
	localparam logic ACC_READ  = 1'b0;
	localparam logic ACC_WRITE = 1'b1;
	// indexes with no register behind them; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int POOL_SIZE   = 6;
	localparam int PHASE_BEATS = 180;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_SHOWN   = 40;

	// one expected result beat
	typedef struct {
		bit plain_hit;
		bit pf_hit;
		bit pf_fill;
		bit [COUNT_BITS-1:0] plain_hits;
		bit [COUNT_BITS-1:0] plain_misses;
		bit [COUNT_BITS-1:0] pf_hits;
		bit [COUNT_BITS-1:0] pf_misses;
		bit [COUNT_BITS-1:0] writes;
	} lookup_t;

	// Tracks both tag stores and the running counts, holds the lookups still owed
	class tag_store_model;
		bit [ADDR_BITS-1:0]  plain_tag [NUM_SETS];
		bit                  plain_ok  [NUM_SETS];
		bit [ADDR_BITS-1:0]  pf_tag    [NUM_SETS];
		bit                  pf_ok     [NUM_SETS];
		bit [COUNT_BITS-1:0] n_plain_hit, n_plain_miss, n_pf_hit, n_pf_miss, n_write;
		int unsigned         offset_bits = 32'(OFFSET_RST);
		int unsigned         index_bits  = 32'(INDEX_RST);
		lookup_t             pending_lookups[$];
		int                  errors, shown, lookups, fills;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_OFFSET_BITS: offset_bits = 32'(val);
				REG_INDEX_BITS:  index_bits = 32'(val[IB_W-1:0]);
				default: ;
			endcase
		endfunction

		function bit [COUNT_BITS-1:0] bump(bit [COUNT_BITS-1:0] c);
			return (c == '1) ? c : c + 1'b1;
		endfunction

		function void note_access(bit is_wr, bit [ADDR_BITS-1:0] addr);
			int unsigned ob, ib, nsets, row;
			bit [ADDR_BITS-1:0] tag;
			lookup_t r;
			ob = (offset_bits > MAX_OFFSET) ? MAX_OFFSET : offset_bits;
			ib = (index_bits > SETS_LOG2) ? SETS_LOG2 : index_bits;
			nsets = 1 << ib;
			row = 32'((addr >> ob) & ADDR_BITS'(nsets - 1));
			tag = addr >> (ob + ib);
			if (is_wr)
				n_write = bump(n_write);
			r.plain_hit = plain_ok[row] && plain_tag[row] == tag;
			if (r.plain_hit) begin
				n_plain_hit = bump(n_plain_hit);
			end else begin
				n_plain_miss = bump(n_plain_miss);
				plain_tag[row] = tag;
				plain_ok[row] = 1'b1;
			end
			r.pf_hit = pf_ok[row] && pf_tag[row] == tag;
			r.pf_fill = 1'b0;
			if (r.pf_hit) begin
				n_pf_hit = bump(n_pf_hit);
			end else begin
				n_pf_miss = bump(n_pf_miss);
				pf_tag[row] = tag;
				pf_ok[row] = 1'b1;
				// no fill past the last set in use
				if (row + 1 < nsets) begin
					pf_tag[row + 1] = tag;
					pf_ok[row + 1] = 1'b1;
					r.pf_fill = 1'b1;
					fills++;
				end
			end
			r.plain_hits = n_plain_hit;
			r.plain_misses = n_plain_miss;
			r.pf_hits = n_pf_hit;
			r.pf_misses = n_pf_miss;
			r.writes = n_write;
			pending_lookups.push_back(r);
			lookups++;
		endfunction

		function void field_ok(string name, logic [COUNT_BITS-1:0] exp,
				logic [COUNT_BITS-1:0] act);
			if (act !== exp) begin
				errors++;
				if (shown < MAX_SHOWN) begin
					$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
					shown++;
				end
			end
		endfunction

		function void check_lookup(logic [OUT_TDATA_W-1:0] d);
			lookup_t e;
			if (pending_lookups.size() == 0) begin
				errors++;
				if (shown < MAX_SHOWN) begin
					$display("%0t: result beat with none pending, expected nothing actual %0h",
						$time, d);
					shown++;
				end
				return;
			end
			e = pending_lookups.pop_front();
			field_ok("plain_hit", COUNT_BITS'(e.plain_hit), COUNT_BITS'(d[0]));
			field_ok("prefetch_hit", COUNT_BITS'(e.pf_hit), COUNT_BITS'(d[1]));
			field_ok("prefetch_done", COUNT_BITS'(e.pf_fill), COUNT_BITS'(d[2]));
			field_ok("plain_hit_count", e.plain_hits, d[3 +: 32]);
			field_ok("plain_miss_count", e.plain_misses, d[35 +: 32]);
			field_ok("pf_hit_count", e.pf_hits, d[67 +: 32]);
			field_ok("pf_miss_count", e.pf_misses, d[99 +: 32]);
			field_ok("write_count", e.writes, d[131 +: 32]);
		endfunction

		function int pending();
			return pending_lookups.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // [47:0] address
	logic                   s_tuser;   // [0] kind (1 = write)
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // plain_hit, prefetch_hit, prefetch_done, 5 counts, pad

	direct_mapped_cache_with_prefetch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	tag_store_model     model;
	bit                 gaps_on, stalls_on;
	int                 stall_left;
	int                 cycles;
	int                 settings;
	int unsigned        eff_ob = 32'(OFFSET_RST);   // offset and index widths as the block sees them
	int unsigned        eff_ib = 32'(INDEX_RST);
	bit [ADDR_BITS-1:0] last_addr;
	bit [ADDR_BITS-1:0] pool [POOL_SIZE];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// generous bound on the whole run, clearing pass included
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d lookups pending", cycles,
				model.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// sink side: random stall bursts on m_tready when enabled
	always @(posedge clk) begin
		if (stall_left == 0 && stalls_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 5);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: values seen here are the ones present before this edge
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			model.note_access(s_tuser, s_tdata[ADDR_BITS-1:0]);
		if (arst_n && m_tvalid && m_tready)
			model.check_lookup(m_tdata);
	end

	function automatic bit [ADDR_BITS-1:0] rand_addr();
		bit [63:0] v;
		v = {$urandom, $urandom};
		return v[ADDR_BITS-1:0];
	endfunction

	// Mostly addresses that revisit or walk lines so both stores see hits,
	// conflicts and prefetched neighbors; a tenth is plain noise.
	function automatic bit [ADDR_BITS-1:0] pick_addr();
		bit [ADDR_BITS-1:0] blk, set_mask, base;
		blk = ADDR_BITS'(1) << eff_ob;
		set_mask = ((ADDR_BITS'(1) << eff_ib) - 1'b1) << eff_ob;
		base = pool[$urandom_range(0, POOL_SIZE - 1)];
		case ($urandom_range(0, 9))
			0, 1, 2: return last_addr + blk;                        // next line
			3, 4, 5: return base ^ (ADDR_BITS'($urandom) & (blk - 1'b1)); // same line
			6, 7:    return (base & ~set_mask) | (last_addr & set_mask); // same set, other tag
			8:       return rand_addr();
			default: return last_addr;
		endcase
	endfunction

	// one access beat; may first idle with s_tvalid low
	task automatic send_access(input logic kind, input bit [ADDR_BITS-1:0] addr);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= IN_TDATA_W'(addr);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// wait until every result beat is back, then let the pipe settle
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (model.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	// writes both registers and one unused index; only called with the block idle
	task automatic apply_settings(input int unsigned ob, input int unsigned ib);
		logic [CFG_DATA_W-1:0] v;
		logic [CFG_IDX_W-1:0]  spare;
		v = CFG_DATA_W'(ob);
		cfg_we    <= 1'b1;
		cfg_index <= REG_OFFSET_BITS;
		cfg_data  <= v;
		@(posedge clk);
		model.write_reg(REG_OFFSET_BITS, v);
		// top data bit has no meaning for the index register
		v = {1'($urandom), IB_W'(ib)};
		cfg_index <= REG_INDEX_BITS;
		cfg_data  <= v;
		@(posedge clk);
		model.write_reg(REG_INDEX_BITS, v);
		spare = $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
		v = CFG_DATA_W'($urandom);
		cfg_index <= spare;
		cfg_data  <= v;
		@(posedge clk);
		model.write_reg(spare, v);
		cfg_we <= 1'b0;
		eff_ob = (ob > MAX_OFFSET) ? MAX_OFFSET : ob;
		eff_ib = (ib > SETS_LOG2) ? SETS_LOG2 : ib;
		settings++;
	endtask

	task automatic run_phase(input int unsigned ob, input int unsigned ib,
			input bit idle);
		bit [ADDR_BITS-1:0] a;
		drain();
		apply_settings(ob, ib);
		foreach (pool[k])
			pool[k] = rand_addr();
		last_addr = pool[0];
		// some phases run without any idling at all
		gaps_on   = idle && $urandom_range(0, 3) != 0;
		stalls_on = idle && $urandom_range(0, 3) != 0;
		repeat (PHASE_BEATS) begin
			a = pick_addr();
			send_access(logic'($urandom_range(0, 1)), a);
			last_addr = a;
		end
	endtask

	int unsigned ob_list [8] = '{0, 16, 31, 17, 5, 2, 9, 20};
	int unsigned ib_list [8] = '{0, 10, 15, 11, 4, 1, 6, 10};

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_OFFSET_BITS;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= ACC_READ;
		m_tready  <= 1'b0;
		model = new();
		settings = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: 4-byte lines, 8 sets. send_access waits out the clearing pass.
		send_access(ACC_READ,  48'h0000_0000_0000); // cold miss, fills set 1
		send_access(ACC_READ,  48'h0000_0000_0004); // prefetched line: pf hit only
		send_access(ACC_WRITE, 48'h0000_0000_0000); // hit in both
		send_access(ACC_WRITE, 48'h0000_0000_001C); // last set: no fill
		send_access(ACC_READ,  48'hFFFF_FFFF_FFFF); // last set, new tag
		send_access(ACC_READ,  48'hFFFF_FFFF_FFFF);
		send_access(ACC_WRITE, 48'h8000_0000_0000); // conflict in set 0
		send_access(ACC_READ,  48'h8000_0000_0007);
		send_access(ACC_WRITE, 48'h0000_0000_0004); // set 1 holds the other tag: misses both

		// single byte lines, single set: never a fill
		drain();
		apply_settings(0, 0);
		send_access(ACC_READ,  48'h0000_0000_0005);
		send_access(ACC_READ,  48'h0000_0000_0005);
		send_access(ACC_WRITE, 48'h0000_0000_0006);
		send_access(ACC_WRITE, 48'h0000_0000_0006);

		// oversized values clamp to 16 offset bits and 1024 sets
		drain();
		apply_settings(31, 15);
		send_access(ACC_WRITE, 48'h0000_0000_0000);
		send_access(ACC_READ,  48'h0000_0001_0000);
		send_access(ACC_READ,  48'h0000_03FF_FFFF); // last set
		send_access(ACC_WRITE, 48'h0000_0400_0000); // conflict with set 0

		for (int p = 0; p < 10; p++) begin
			if (p < 8)
				run_phase(ob_list[p], ib_list[p], 1'b1);
			else
				run_phase($urandom_range(0, 31), $urandom_range(0, 15), p < 9);
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Checked %0d lookups over %0d register settings, %0d mismatches",
			model.lookups, settings, model.errors);
		$display("Plain store hits %0d, prefetch store hits %0d, next-set fills %0d",
			model.n_plain_hit, model.n_pf_hit, model.fills);
		if (model.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/dmc_pkg.sv
sv/dmc_ram.sv
sv/dmc_split.sv
sv/dmc_counters.sv
sv/direct_mapped_cache_with_prefetch.sv
tb/sv/tb.sv
